### sv/fsic_pkg.sv
// ----------------------------------------------------------------------------
// fsic_pkg: shared types and constants for the interface coupling block
// Word formats, shift codes, sequencer states, Gauss and shape constants.
// ----------------------------------------------------------------------------
package fsic_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ACC_W      = 48;
    localparam int CONST_FRAC = 30;
    localparam int NUM_NODES  = 4;
    localparam int NUM_SDOF   = 12;
    localparam int NUM_FORCES = 16;
    localparam int Q_DEPTH    = NUM_SDOF * NUM_NODES;
    localparam int PROD_W     = 2 * ACC_W + 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                   node_slot;
        logic signed [DATA_WIDTH-1:0] coord_x;
        logic signed [DATA_WIDTH-1:0] coord_y;
        logic signed [DATA_WIDTH-1:0] coord_z;
        logic signed [DATA_WIDTH-1:0] accel_x;
        logic signed [DATA_WIDTH-1:0] accel_y;
        logic signed [DATA_WIDTH-1:0] accel_z;
        logic signed [DATA_WIDTH-1:0] fluid_pressure;
        logic                         last_node;
    } t_node_word;

    typedef struct packed {
        logic [3:0]              dof_index;
        logic signed [ACC_W-1:0] force_value;
        logic                    last_force;
    } t_force_word;

    // Product scaling: Jacobian factor, shape value, fixed-point data
    typedef enum logic [1:0] {
        SH_JAC,
        SH_SHAPE,
        SH_FRAC
    } t_shift;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        t_shift                  sh;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] res;
    } t_mul_rsp;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_FETCH,
        CS_FETCH2,
        CS_ISSUE,
        CS_WAIT,
        CS_EMIT
    } t_ctrl_state;

    typedef enum logic [2:0] {
        PH_JAC,
        PH_CROSS,
        PH_HN,
        PH_Q,
        PH_FORCE
    } t_phase;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'd1 << 62;
        x = v;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Gauss abscissa 1/sqrt3 in Q30, and 1 -/+ g
    localparam logic [63:0] G_SQ  = (64'd1 << 60) / 64'd3;
    localparam logic [63:0] G_ABS = isqrt64(G_SQ);
    localparam logic [63:0] F_LO  = (64'd1 << CONST_FRAC) - G_ABS;
    localparam logic [63:0] F_HI  = (64'd1 << CONST_FRAC) + G_ABS;

    // Shape values: product of two factors, rounded, shifted by 32
    localparam logic [63:0] H_HI  = (F_HI * F_HI + (64'd1 << 31)) >> 32;
    localparam logic [63:0] H_MID = (F_HI * F_LO + (64'd1 << 31)) >> 32;
    localparam logic [63:0] H_LO  = (F_LO * F_LO + (64'd1 << 31)) >> 32;

    function automatic logic signed [ACC_W-1:0] shape_val(input logic [1:0] pt,
                                                          input logic [1:0] node);
        logic r_hi;
        logic s_hi;
        logic [63:0] v;
        r_hi = (node == 2'd1 || node == 2'd2) ? pt[1] : !pt[1];
        s_hi = node[1] ? pt[0] : !pt[0];
        if (r_hi && s_hi) begin
            v = H_HI;
        end else if (r_hi || s_hi) begin
            v = H_MID;
        end else begin
            v = H_LO;
        end
        return v[ACC_W-1:0];
    endfunction

    function automatic logic [5:0] shift_amt(input t_shift s);
        logic [5:0] a;
        unique case (s)
            SH_JAC:   a = 6'd32;
            SH_SHAPE: a = 6'(CONST_FRAC);
            SH_FRAC:  a = 6'(FRAC_BITS);
            default:  a = 6'd32;
        endcase
        return a;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] x,
                                                        input logic signed [ACC_W-1:0] y,
                                                        input logic sub);
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] r;
        s = sub ? ({x[ACC_W-1], x} - {y[ACC_W-1], y}) : ({x[ACC_W-1], x} + {y[ACC_W-1], y});
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sext_data(
            input logic signed [DATA_WIDTH-1:0] d);
        return {{(ACC_W-DATA_WIDTH){d[DATA_WIDTH-1]}}, d};
    endfunction

endpackage

### sv/fsic_mul_unit.sv
// ----------------------------------------------------------------------------
// fsic_mul_unit: shared multiply, round and saturate unit
// Sign-magnitude 48x48 product from four 24x24 partial products, then
// round half away from zero, shift and clip to 48 signed bits.
// ----------------------------------------------------------------------------
module fsic_mul_unit
    import fsic_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int HALF = ACC_W / 2;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [ACC_W-1:0]  r_ma;
    logic [ACC_W-1:0]  r_mb;
    logic              r_neg;
    t_shift            r_sh;
    logic [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_res;

    logic [HALF-1:0]   a_half;
    logic [HALF-1:0]   b_half;
    logic [ACC_W-1:0]  pp;
    logic [PROD_W-1:0] pp_sh;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] limit;
    logic [ACC_W-1:0]  mag_c;
    logic [5:0]        amt;

    always_comb begin
        a_half = r_step[0] ? r_ma[ACC_W-1:HALF] : r_ma[HALF-1:0];
        b_half = r_step[1] ? r_mb[ACC_W-1:HALF] : r_mb[HALF-1:0];
        pp     = a_half * b_half;
        unique case ({r_step[1], r_step[0]})
            2'b00:   pp_sh = PROD_W'(pp);
            2'b11:   pp_sh = PROD_W'(pp) << (2 * HALF);
            default: pp_sh = PROD_W'(pp) << HALF;
        endcase
        amt   = shift_amt(r_sh);
        mag   = r_prod >> amt;
        limit = r_neg ? (PROD_W'(1) << (ACC_W - 1)) : ((PROD_W'(1) << (ACC_W - 1)) - 1'b1);
        mag_c = (mag > limit) ? limit[ACC_W-1:0] : mag[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= i_req.a[ACC_W-1] ? (~i_req.a + 1'b1) : i_req.a;
            r_mb   <= i_req.b[ACC_W-1] ? (~i_req.b + 1'b1) : i_req.b;
            r_neg  <= i_req.a[ACC_W-1] ^ i_req.b[ACC_W-1];
            r_sh   <= i_req.sh;
            r_prod <= '0;
        end else if (r_busy) begin
            if (r_step < 3'd4) begin
                r_prod <= r_prod + pp_sh;
            end else if (r_step == 3'd4) begin
                // add half an output LSB before the shift
                r_prod <= r_prod + (PROD_W'(1) << (amt - 6'd1));
            end else begin
                r_res <= r_neg ? -$signed(mag_c) : $signed(mag_c);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiply started while unit busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held longer than one cycle");

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("done without a running product");

endmodule

### sv/fluid_structure_interface_coupling.sv
// ----------------------------------------------------------------------------
// fluid_structure_interface_coupling: quad interface coupling forces
// Loads four nodes, builds the 12x4 coupling matrix and emits 16 forces.
// ----------------------------------------------------------------------------
// Usage:
//   Input words go in by command: a word is taken at a clock edge where
//   start is high and busy is low. A word without last_node just stores
//   that node's coordinates, accelerations and pressure; busy stays low.
//   A word with last_node stores its node, then the block raises busy
//   and runs the element: four Gauss points of Jacobian, normal and
//   coupling accumulation, then the sixteen force sums.
//   Every product goes through one shared multiply unit (operand fetch,
//   four partial products, round, clip), which takes a new product only
//   once the last is done; that unit sets the rate: an element needs 408
//   products plus the sixteen force emits after the last node word, and the
//   sixteen result words come out spread over that run, the last one in
//   the cycle busy drops. Each result word shows on o_result for one cycle
//   with o_result_strobe high; the receiver cannot stall it.
//   include_inertia is written through i_cfg_wr_en / i_cfg_wr_data; the user
//   must write it only while idle, the block does not enforce it. Synchronous
//   reset idles the sequencer and sets include_inertia; node stores keep no reset value.
// ----------------------------------------------------------------------------
module fluid_structure_interface_coupling
    import fsic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_node_word  i_cmd,
    output logic        busy,
    output logic        o_result_strobe,
    output t_force_word o_result,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    localparam logic [3:0] FIRST_FLUID = 4'(NUM_SDOF);
    localparam logic [3:0] LAST_FORCE  = 4'(NUM_FORCES - 1);
    localparam logic [3:0] LAST_SDOF   = 4'(NUM_SDOF - 1);

    // node stores
    logic signed [DATA_WIDTH-1:0] r_coord [NUM_SDOF];
    logic signed [DATA_WIDTH-1:0] r_accel [NUM_SDOF];
    logic signed [DATA_WIDTH-1:0] r_press [NUM_NODES];

    // coupling matrix memory, row-major 12 x 4
    logic signed [ACC_W-1:0] r_qmem [Q_DEPTH];
    logic signed [ACC_W-1:0] r_qrd;

    t_ctrl_state r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_pt, n_pt;
    logic [1:0]  r_c, n_c;
    logic [1:0]  r_t, n_t;
    logic [1:0]  r_i, n_i;
    logic [3:0]  r_j, n_j;
    logic [3:0]  r_k, n_k;
    logic        r_inertia;

    logic signed [ACC_W-1:0] r_j0 [3];
    logic signed [ACC_W-1:0] n_j0 [3];
    logic signed [ACC_W-1:0] r_j1 [3];
    logic signed [ACC_W-1:0] n_j1 [3];
    logic signed [ACC_W-1:0] r_n [3];
    logic signed [ACC_W-1:0] n_n [3];
    logic signed [ACC_W-1:0] r_hn, n_hn;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [DATA_WIDTH-1:0] r_xa;

    logic        r_strobe, n_strobe;
    t_force_word r_out, n_out;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic                    acc_in;
    logic [3:0]              node_base;
    logic [3:0]              c4;
    logic [3:0]              xa_addr;
    logic [3:0]              xb_addr;
    logic [3:0]              coord_addr;
    logic signed [DATA_WIDTH-1:0] coord_rd;
    logic signed [DATA_WIDTH:0]   coord_diff;
    logic [1:0]              u_idx;
    logic [1:0]              v_idx;
    logic [3:0]              row_q;
    logic [5:0]              q_addr;
    logic                    q_we;
    logic signed [ACC_W-1:0] q_wdata;
    logic                    is_fluid;
    logic                    fac_hi;
    logic signed [ACC_W-1:0] m;
    logic                    force_last;

    fsic_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign busy   = (r_state != CS_IDLE);
    assign acc_in = start && !busy;
    assign m      = mul_rsp.res;

    // ---------------------------------------------------------------------
    // Address generation
    // ---------------------------------------------------------------------
    always_comb begin
        node_base = {1'b0, i_cmd.node_slot, 1'b0} + {2'b00, i_cmd.node_slot};
        c4        = {2'b00, r_c};
        // Jacobian differences: x[b] - x[a] per term
        unique case (r_t)
            2'd0: begin xa_addr = c4;        xb_addr = c4 + 4'd3; end
            2'd1: begin xa_addr = c4 + 4'd9; xb_addr = c4 + 4'd6; end
            2'd2: begin xa_addr = c4;        xb_addr = c4 + 4'd9; end
            default: begin xa_addr = c4 + 4'd3; xb_addr = c4 + 4'd6; end
        endcase
        coord_addr = (r_state == CS_FETCH) ? xa_addr : xb_addr;
        coord_rd   = r_coord[coord_addr];
        coord_diff = {coord_rd[DATA_WIDTH-1], coord_rd} - {r_xa[DATA_WIDTH-1], r_xa};

        // cyclic neighbors for the cross product
        unique case (r_c)
            2'd0:    begin u_idx = 2'd1; v_idx = 2'd2; end
            2'd1:    begin u_idx = 2'd2; v_idx = 2'd0; end
            default: begin u_idx = 2'd0; v_idx = 2'd1; end
        endcase

        is_fluid = (r_k >= FIRST_FLUID);
        row_q    = {1'b0, r_i, 1'b0} + {2'b00, r_i} + c4;
        if (r_phase == PH_Q) begin
            q_addr = {row_q, r_j[1:0]};
        end else if (is_fluid) begin
            q_addr = {r_j, r_k[1:0]};
        end else begin
            q_addr = {r_k, r_j[1:0]};
        end

        // Jacobian factor: 1+g or 1-g depending on term and Gauss point
        fac_hi = r_t[1] ? (r_t[0] ? r_pt[1] : !r_pt[1]) : (r_t[0] ? r_pt[0] : !r_pt[0]);
    end

    // ---------------------------------------------------------------------
    // Operand select for the shared unit
    // ---------------------------------------------------------------------
    always_comb begin
        mul_req.start = (r_state == CS_ISSUE);
        mul_req.a     = r_qrd;
        mul_req.b     = '0;
        mul_req.sh    = SH_FRAC;
        unique case (r_phase)
            PH_JAC: begin
                mul_req.a  = {{(ACC_W-DATA_WIDTH-1){coord_diff[DATA_WIDTH]}}, coord_diff};
                mul_req.b  = fac_hi ? F_HI[ACC_W-1:0] : F_LO[ACC_W-1:0];
                mul_req.sh = SH_JAC;
            end
            PH_CROSS: begin
                mul_req.a  = r_t[0] ? r_j0[v_idx] : r_j0[u_idx];
                mul_req.b  = r_t[0] ? r_j1[u_idx] : r_j1[v_idx];
                mul_req.sh = SH_FRAC;
            end
            PH_HN: begin
                mul_req.a  = r_n[r_c];
                mul_req.b  = shape_val(r_pt, r_i);
                mul_req.sh = SH_SHAPE;
            end
            PH_Q: begin
                mul_req.a  = r_hn;
                mul_req.b  = shape_val(r_pt, r_j[1:0]);
                mul_req.sh = SH_SHAPE;
            end
            PH_FORCE: begin
                mul_req.a  = r_qrd;
                mul_req.b  = is_fluid ? sext_data(r_accel[r_j]) : sext_data(r_press[r_j[1:0]]);
                mul_req.sh = SH_FRAC;
            end
            default: begin
                mul_req.a  = r_qrd;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state, counters and writeback
    // ---------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_pt     = r_pt;
        n_c      = r_c;
        n_t      = r_t;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_j0     = r_j0;
        n_j1     = r_j1;
        n_n      = r_n;
        n_hn     = r_hn;
        n_acc    = r_acc;
        n_strobe = 1'b0;
        n_out    = r_out;
        q_we     = 1'b0;
        q_wdata  = (r_pt == 2'd0) ? m : sat_add(r_qrd, m, 1'b0);
        force_last = is_fluid ? (r_j == LAST_SDOF) : (r_j[1:0] == 2'd3);

        unique case (r_state)
            CS_IDLE: begin
                if (acc_in && i_cmd.last_node) begin
                    n_state = CS_FETCH;
                    n_phase = PH_JAC;
                    n_pt    = '0;
                    n_c     = '0;
                    n_t     = '0;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            CS_FETCH:  n_state = CS_FETCH2;
            CS_FETCH2: n_state = CS_ISSUE;
            CS_ISSUE:  n_state = CS_WAIT;
            CS_WAIT: begin
                if (mul_rsp.done) begin
                    n_state = CS_FETCH;
                    unique case (r_phase)
                        PH_JAC: begin
                            // even term opens the sum, odd term adds
                            if (!r_t[1]) begin
                                n_j0[r_c] = r_t[0] ? sat_add(r_j0[r_c], m, 1'b0) : m;
                            end else begin
                                n_j1[r_c] = r_t[0] ? sat_add(r_j1[r_c], m, 1'b0) : m;
                            end
                            n_t = r_t + 2'd1;
                            if (r_t == 2'd3) begin
                                if (r_c == 2'd2) begin
                                    n_c     = '0;
                                    n_phase = PH_CROSS;
                                end else begin
                                    n_c = r_c + 2'd1;
                                end
                            end
                        end
                        PH_CROSS: begin
                            n_n[r_c] = r_t[0] ? sat_add(r_n[r_c], m, 1'b1) : m;
                            if (r_t[0]) begin
                                n_t = '0;
                                if (r_c == 2'd2) begin
                                    n_c     = '0;
                                    n_i     = '0;
                                    n_phase = PH_HN;
                                end else begin
                                    n_c = r_c + 2'd1;
                                end
                            end else begin
                                n_t = 2'd1;
                            end
                        end
                        PH_HN: begin
                            n_hn    = m;
                            n_j     = '0;
                            n_phase = PH_Q;
                        end
                        PH_Q: begin
                            q_we = 1'b1;
                            if (r_j[1:0] == 2'd3) begin
                                n_j     = '0;
                                n_phase = PH_HN;
                                if (r_c == 2'd2) begin
                                    n_c = '0;
                                    if (r_i == 2'd3) begin
                                        n_i = '0;
                                        if (r_pt == 2'd3) begin
                                            n_phase = PH_FORCE;
                                            n_k     = '0;
                                        end else begin
                                            n_pt    = r_pt + 2'd1;
                                            n_t     = '0;
                                            n_phase = PH_JAC;
                                        end
                                    end else begin
                                        n_i = r_i + 2'd1;
                                    end
                                end else begin
                                    n_c = r_c + 2'd1;
                                end
                            end else begin
                                n_j = r_j + 4'd1;
                            end
                        end
                        PH_FORCE: begin
                            // first term of each force starts from zero
                            n_acc = sat_add((r_j == 4'd0) ? '0 : r_acc, m, is_fluid);
                            if (force_last) begin
                                n_state = CS_EMIT;
                            end else begin
                                n_j = r_j + 4'd1;
                            end
                        end
                        default: n_state = CS_IDLE;
                    endcase
                end
            end
            CS_EMIT: begin
                n_strobe              = 1'b1;
                n_out.dof_index       = r_k;
                n_out.force_value     = (is_fluid && !r_inertia) ? '0 : r_acc;
                n_out.last_force      = (r_k == LAST_FORCE);
                n_j                   = '0;
                if (r_k == LAST_FORCE) begin
                    n_state = CS_IDLE;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = CS_FETCH;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= CS_IDLE;
            r_phase   <= PH_JAC;
            r_pt      <= '0;
            r_c       <= '0;
            r_t       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_strobe  <= 1'b0;
            r_inertia <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_pt     <= n_pt;
            r_c      <= n_c;
            r_t      <= n_t;
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_strobe <= n_strobe;
            if (i_cfg_wr_en) begin
                r_inertia <= i_cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_j0  <= n_j0;
        r_j1  <= n_j1;
        r_n   <= n_n;
        r_hn  <= n_hn;
        r_acc <= n_acc;
        r_out <= n_out;
        if (r_state == CS_FETCH) begin
            r_xa <= coord_rd;
        end
    end

    // node stores: overwrite the slot on every accepted word
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_coord[node_base]        <= i_cmd.coord_x;
            r_coord[node_base + 4'd1] <= i_cmd.coord_y;
            r_coord[node_base + 4'd2] <= i_cmd.coord_z;
            r_accel[node_base]        <= i_cmd.accel_x;
            r_accel[node_base + 4'd1] <= i_cmd.accel_y;
            r_accel[node_base + 4'd2] <= i_cmd.accel_z;
            r_press[i_cmd.node_slot]  <= i_cmd.fluid_pressure;
        end
    end

    // coupling matrix: read during fetch, write back at product done
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_addr] <= q_wdata;
        end
        if (r_state == CS_FETCH) begin
            r_qrd <= r_qmem[q_addr];
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_out;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last_force) |-> !busy)
        else $error("still busy after the last force word");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_result.last_force == (o_result.dof_index == LAST_FORCE)))
        else $error("last_force out of step with dof index");

    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.last_node) |=> busy)
        else $error("last node word did not start the element run");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !mul_rsp.done)
        else $error("multiply result arrived while idle");

endmodule

### verif/fluid_structure_interface_coupling_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fluid_structure_interface_coupling_tb: self-checking bench for the coupling
// Loads quad interface elements through the command port, predicts the
// sixteen forces of each element and compares every strobed result word.
// ----------------------------------------------------------------------------
module fluid_structure_interface_coupling_tb;
    import fsic_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int ELEM_CYCLES = 4096;
    localparam longint signed SAT_HI = 64'sd140737488355327;
    localparam longint signed SAT_LO = -64'sd140737488355328;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_node_word  i_cmd;
    logic        busy;
    logic        o_result_strobe;
    t_force_word o_result;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;

    fluid_structure_interface_coupling i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    // Free-running clock, 8 ns period
    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    // Pending node words, expected force words, and the predictor's state
    t_node_word  node_queue[$];
    t_force_word force_expect[$];
    longint signed model_coord[12];
    longint signed model_accel[12];
    longint signed model_press[4];
    longint signed coupling_q[12][4];
    bit            model_inertia;

    int  mismatch_count;
    int  forces_seen;
    int  elements_sent;
    int  words_sent;
    bit  quiet_driver;     // no idling in the final stretch
    int  gap_left;
    bit  hold_driver;      // initial block parks the driver to write config

    // ------------------------------------------------------------------------
    // Fixed-point helpers: round half away from zero, clip to 48 signed bits
    // ------------------------------------------------------------------------
    function automatic longint signed clip48(input logic signed [127:0] v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return longint'(v);
    endfunction

    function automatic longint signed mul_round(input longint signed a,
                                                input longint signed b,
                                                input int sh);
        logic signed [127:0] p;
        logic        [127:0] mag;
        bit                  neg;
        p   = 128'(a) * 128'(b);
        neg = p < 0;
        mag = neg ? 128'(-p) : 128'(p);
        mag = (mag + (128'd1 << (sh - 1))) >> sh;
        return neg ? clip48(-$signed(mag)) : clip48($signed(mag));
    endfunction

    function automatic longint signed add_clip(input longint signed a,
                                               input longint signed b);
        return clip48(128'(a) + 128'(b));
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, bt;
        r  = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    // Build Q over the 2x2 Gauss points (r outer, s inner, each -g then +g)
    task automatic build_q_matrix();
        longint signed g, f_lo, f_hi, rl, rh, sl, sh2, hn;
        longint signed h[4], ja[3], jb[3], nv[3];
        g    = longint'(int_sqrt((64'd1 << 60) / 3));
        f_lo = (64'sd1 << CONST_FRAC) - g;
        f_hi = (64'sd1 << CONST_FRAC) + g;
        foreach (coupling_q[a, b]) coupling_q[a][b] = 0;
        for (int ri = 0; ri < 2; ri++) begin
            rl = ri == 0 ? f_hi : f_lo;
            rh = ri == 0 ? f_lo : f_hi;
            for (int si = 0; si < 2; si++) begin
                sl  = si == 0 ? f_hi : f_lo;
                sh2 = si == 0 ? f_lo : f_hi;
                h[0] = mul_round(rl, sl, 32);
                h[1] = mul_round(rh, sl, 32);
                h[2] = mul_round(rh, sh2, 32);
                h[3] = mul_round(rl, sh2, 32);
                for (int c = 0; c < 3; c++) begin
                    ja[c] = add_clip(
                        mul_round(model_coord[3+c] - model_coord[c], sl, 32),
                        mul_round(model_coord[6+c] - model_coord[9+c], sh2, 32));
                    jb[c] = add_clip(
                        mul_round(model_coord[9+c] - model_coord[c], rl, 32),
                        mul_round(model_coord[6+c] - model_coord[3+c], rh, 32));
                end
                nv[0] = add_clip(mul_round(ja[1], jb[2], FRAC_BITS),
                                 -mul_round(ja[2], jb[1], FRAC_BITS));
                nv[1] = add_clip(mul_round(ja[2], jb[0], FRAC_BITS),
                                 -mul_round(ja[0], jb[2], FRAC_BITS));
                nv[2] = add_clip(mul_round(ja[0], jb[1], FRAC_BITS),
                                 -mul_round(ja[1], jb[0], FRAC_BITS));
                for (int i = 0; i < 4; i++)
                    for (int c = 0; c < 3; c++) begin
                        hn = mul_round(nv[c], h[i], CONST_FRAC);
                        for (int j = 0; j < 4; j++)
                            coupling_q[3*i+c][j] = add_clip(coupling_q[3*i+c][j],
                                mul_round(hn, h[j], CONST_FRAC));
                    end
            end
        end
    endtask

    // Store one accepted node word; on the last node push the sixteen forces
    task automatic predict_forces(input t_node_word w);
        longint signed acc;
        t_force_word   fw;
        model_coord[3*w.node_slot]   = w.coord_x;
        model_coord[3*w.node_slot+1] = w.coord_y;
        model_coord[3*w.node_slot+2] = w.coord_z;
        model_accel[3*w.node_slot]   = w.accel_x;
        model_accel[3*w.node_slot+1] = w.accel_y;
        model_accel[3*w.node_slot+2] = w.accel_z;
        model_press[w.node_slot]     = w.fluid_pressure;
        if (!w.last_node) return;
        build_q_matrix();
        for (int k = 0; k < NUM_FORCES; k++) begin
            acc = 0;
            if (k < NUM_SDOF) begin
                for (int j = 0; j < 4; j++)
                    acc = add_clip(acc, mul_round(coupling_q[k][j], model_press[j],
                                                  FRAC_BITS));
            end else if (model_inertia) begin
                for (int j = 0; j < NUM_SDOF; j++)
                    acc = add_clip(acc, -mul_round(coupling_q[j][k-NUM_SDOF],
                                                   model_accel[j], FRAC_BITS));
            end
            fw.dof_index   = 4'(k);
            fw.force_value = acc[ACC_W-1:0];
            fw.last_force  = k == NUM_FORCES - 1;
            force_expect.push_back(fw);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: at the falling edge, present the next word unless idling.
    // The word is taken at the rising edge where start is high and busy low.
    // ------------------------------------------------------------------------
    bit driving;
    bit took;             // word taken at the last rising edge

    always @(posedge i_clk) begin
        took <= i_rst_n && start && !busy;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (driving && took) begin
                // previous word was accepted at the last rising edge
                predict_forces(i_cmd);
                void'(node_queue.pop_front());
                words_sent++;
                driving = 1'b0;
            end
            if (!driving) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!quiet_driver && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 19);
                end
            end
            if (!driving && gap_left == 0 && !hold_driver && node_queue.size() > 0) begin
                driving = 1'b1;
                i_cmd   <= node_queue[0];
            end
            start <= driving;
        end
    end

    // Monitor: sample result words at the rising edge
    always @(posedge i_clk) begin
        t_force_word want;
        if (i_rst_n && o_result_strobe) begin
            forces_seen++;
            if (force_expect.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected force word dof %0d value %0d",
                             o_result.dof_index, o_result.force_value);
            end else begin
                want = force_expect.pop_front();
                if (o_result !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: force dof %0d/%0d value exp %0d got %0d last exp %0b got %0b",
                                 want.dof_index, o_result.dof_index, want.force_value,
                                 o_result.force_value, want.last_force, o_result.last_force);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_data(input int mode);
        case (mode)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom_range(0, 3) == 0 ? $urandom()
                   : 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
        endcase
    endfunction

    function automatic t_node_word make_word(input logic [1:0] slot, input bit last,
                                             input int mode);
        t_node_word w;
        w.node_slot      = slot;
        w.coord_x        = pick_data(mode);
        w.coord_y        = pick_data(mode);
        w.coord_z        = pick_data(mode);
        w.accel_x        = pick_data(mode);
        w.accel_y        = pick_data(mode);
        w.accel_z        = pick_data(mode);
        w.fluid_pressure = pick_data(mode);
        w.last_node      = last;
        return w;
    endfunction

    // Queue one element: slots 0..3 in random order, the last one flagged
    task automatic queue_element(input int mode);
        logic [1:0] order[4];
        int         p;
        logic [1:0] t;
        order = '{2'd0, 2'd1, 2'd2, 2'd3};
        for (int k = 3; k > 0; k--) begin
            p = $urandom_range(0, k);
            t = order[k]; order[k] = order[p]; order[p] = t;
        end
        for (int k = 0; k < 4; k++) node_queue.push_back(make_word(order[k], k == 3, mode));
        elements_sent++;
    endtask

    // Wait for the queue and all forces to drain, then a further settling wait
    task automatic drain_all();
        wait (node_queue.size() == 0 && !driving);
        wait (force_expect.size() == 0);
        repeat (ELEM_CYCLES / 8) @(posedge i_clk);
    endtask

    // Drain, park the driver, then write include_inertia
    task automatic set_inertia(input bit v);
        drain_all();
        hold_driver = 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_inertia = v;
        hold_driver = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        model_inertia = 1'b1;
        mismatch_count = 0;
        forces_seen = 0;
        elements_sent = 0;
        words_sent = 0;
        quiet_driver = 1'b0;
        gap_left = 0;
        hold_driver = 1'b1;
        driving = 1'b0;
        foreach (model_coord[k]) begin
            model_coord[k] = 0;
            model_accel[k] = 0;
        end
        foreach (model_press[k]) model_press[k] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        hold_driver = 1'b0;

        // Directed: zeros, both extremes of every field, a repeated slot
        queue_element(2);
        queue_element(0);
        queue_element(1);
        node_queue.push_back(make_word(2'd1, 1'b0, 3));
        node_queue.push_back(make_word(2'd1, 1'b0, 3));   // overwrite same slot
        node_queue.push_back(make_word(2'd2, 1'b1, 3));   // stale slots reused
        // Inertia off, both with extreme and typical data
        set_inertia(1'b0);
        queue_element(0);
        queue_element(3);
        set_inertia(1'b1);

        // Random: mostly full elements, some partial reloads of stale nodes
        while (words_sent + node_queue.size() < 130) begin
            if ($urandom_range(0, 3) == 0) begin
                node_queue.push_back(make_word(2'($urandom_range(0, 3)),
                                               1'b0, $urandom_range(0, 6)));
                node_queue.push_back(make_word(2'($urandom_range(0, 3)),
                                               1'b1, 3));
            end else begin
                queue_element($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 3);
            end
            if (node_queue.size() > 20) begin
                if ($urandom_range(0, 2) == 0) set_inertia($urandom_range(0, 1));
                else wait (node_queue.size() < 8);
            end
        end
        // Final stretch: no idling, end with inertia on
        set_inertia(1'b1);
        quiet_driver = 1'b1;
        queue_element(3);
        queue_element(3);
        drain_all();

        $display("Loaded %0d node words over %0d elements, checked %0d forces,",
                 words_sent, elements_sent, forces_seen);
        $display("with inertia on and off, extremes, repeated and stale slots.");
        if (mismatch_count == 0 && force_expect.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #(4 * 2 * HALF_PERIOD * 80 * (ELEM_CYCLES + 100));
        $display("Verification failed");
        $finish;
    end

endmodule

### fluid_structure_interface_coupling.f
sv/fsic_pkg.sv
sv/fsic_mul_unit.sv
sv/fluid_structure_interface_coupling.sv
verif/fluid_structure_interface_coupling_tb.sv
